[hdl/svpwm_pkg.sv]
`timescale 1ns / 1ps
// shared constants and helpers for the space vector pwm timing unit
// no dependencies
package svpwm_pkg;

  localparam int VOLT_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF = 16;

  // sqrt(3) scaled by 2^14, rounded
  localparam int SQRT3_Q14 = 28378;
  // 3 * 2^14, used for the scaled alpha term
  localparam int THREE_Q14 = 49152;

  // configuration register indexes
  localparam int unsigned REG_BUS_VOLTAGE = 0;
  localparam int unsigned REG_PWM_PERIOD  = 1;

  // sector from the sign code {ref3 > 0, ref2 > 0, ref1 > 0}
  function automatic logic [2:0] sector_of(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd1:    s = 3'd2;
      3'd2:    s = 3'd6;
      3'd3:    s = 3'd1;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd3;
      3'd6:    s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

[hdl/svpwm_div.sv]
`timescale 1ns / 1ps
// pipelined scaled divider: q = floor(p * n / d) for n <= d, one period bit per stage
// uses no package; instantiated by space_vector_pwm_timing_unit
module svpwm_div #(
  parameter int TIME_WIDTH = 16,
  parameter int DIV_WIDTH  = 35
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [TIME_WIDTH-1:0] p,
  input  logic [DIV_WIDTH-1:0]  n,
  input  logic [DIV_WIDTH-1:0]  d,
  output logic [TIME_WIDTH-1:0] q
);

  localparam int RW = DIV_WIDTH + 2;

  logic [DIV_WIDTH-1:0]  rem_r [TIME_WIDTH];
  logic [TIME_WIDTH-1:0] quo_r [TIME_WIDTH];
  logic [DIV_WIDTH-1:0]  num_r [TIME_WIDTH];
  logic [DIV_WIDTH-1:0]  den_r [TIME_WIDTH];

  genvar i;
  for (i = 0; i < TIME_WIDTH; i++) begin : g_stage
    logic [DIV_WIDTH-1:0]  rem_in;
    logic [TIME_WIDTH-1:0] quo_in;
    logic [DIV_WIDTH-1:0]  num_in;
    logic [DIV_WIDTH-1:0]  den_in;
    logic [RW-1:0]         acc;
    logic [RW-1:0]         sub1;
    logic [RW-1:0]         sub2;
    logic [DIV_WIDTH-1:0]  rem_nxt;
    logic [TIME_WIDTH-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = n;
      assign den_in = d;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
    end

    // shift in one period bit, then take off the divisor up to twice
    always_comb begin
      acc  = (RW'(rem_in) << 1) + (p[TIME_WIDTH-1-i] ? RW'(num_in) : RW'(0));
      sub1 = acc - RW'(den_in);
      sub2 = acc - (RW'(den_in) << 1);
      if (acc >= (RW'(den_in) << 1)) begin
        rem_nxt = sub2[DIV_WIDTH-1:0];
        quo_nxt = (quo_in << 1) + TIME_WIDTH'(2);
      end else if (acc >= RW'(den_in)) begin
        rem_nxt = sub1[DIV_WIDTH-1:0];
        quo_nxt = (quo_in << 1) + TIME_WIDTH'(1);
      end else begin
        rem_nxt = acc[DIV_WIDTH-1:0];
        quo_nxt = quo_in << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        quo_r[i] <= quo_nxt;
        num_r[i] <= num_in;
        den_r[i] <= den_in;
      end
    end
  end

  assign q = quo_r[TIME_WIDTH-1];

endmodule

[hdl/space_vector_pwm_timing_unit.sv]
`timescale 1ns / 1ps
// space vector pwm timing, seven-segment scheme, fully pipelined
// depends on svpwm_pkg and svpwm_div
// a reference passes stages 1 to 3, the divider, zero-vector and output registers
// throughput: one reference per cycle; the whole pipe stalls only while the
// output register holds a result that is not taken
// the divider depth is one stage per period bit (two lanes, t1 and t2)
// reset (rst_n low, synchronous): all valid bits clear, bus voltage and period to 1
module space_vector_pwm_timing_unit #(
  parameter int VOLT_WIDTH = svpwm_pkg::VOLT_WIDTH_DEF,
  parameter int TIME_WIDTH = svpwm_pkg::TIME_WIDTH_DEF,
  localparam int IN_W  = ((2 * VOLT_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 + 3 * TIME_WIDTH + 7) / 8) * 8,
  localparam int CFG_W = (VOLT_WIDTH > TIME_WIDTH) ? VOLT_WIDTH : TIME_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: v_alpha, v_beta
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  // out_tdata: sector, time_phase_a, time_phase_b, time_phase_c
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int SW = VOLT_WIDTH + 19;  // signed intermediates
  localparam int NW = VOLT_WIDTH + 18;  // dwell numerators
  localparam int DW = VOLT_WIDTH + 19;  // divisor width
  localparam int TW = TIME_WIDTH;

  // configuration registers
  logic [VOLT_WIDTH-1:0] bus_r;
  logic [TW-1:0]         period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r    <= VOLT_WIDTH'(1);
      period_r <= TW'(1);
    end else if (cfg_we) begin
      if (cfg_addr == 1'(svpwm_pkg::REG_BUS_VOLTAGE)) begin
        bus_r <= cfg_wdata[VOLT_WIDTH-1:0];
      end else begin
        period_r <= cfg_wdata[TW-1:0];
      end
    end
  end

  // global advance: the pipe moves whenever the output register can take data
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: products
  logic signed [VOLT_WIDTH-1:0] a_in, b_in;
  logic signed [SW-1:0] a3_r, bk_r, ka_r, bs_r;
  logic                 v1_r;

  assign a_in = in_tdata[VOLT_WIDTH-1:0];
  assign b_in = in_tdata[2*VOLT_WIDTH-1:VOLT_WIDTH];

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r <= SW'(a_in) * SW'(svpwm_pkg::THREE_Q14);
      bk_r <= SW'(b_in) * SW'(svpwm_pkg::SQRT3_Q14);
      ka_r <= SW'(a_in) * SW'(svpwm_pkg::SQRT3_Q14);
      bs_r <= SW'(b_in) <<< 14;
    end
  end

  // stage 2: sector and dwell numerators
  logic signed [SW-1:0] r2, r3, x1, x2, x3, x4, n1s, n2s;
  logic [2:0]           sec2;
  logic [2:0]           sec_r;
  logic [NW-1:0]        n1_r, n2_r;
  logic                 v2_r;

  always_comb begin
    r2   = ka_r - bs_r;
    r3   = -ka_r - bs_r;
    sec2 = svpwm_pkg::sector_of({r3 > 0, r2 > 0, bs_r > 0});
    x1   = a3_r - bk_r;
    x2   = bk_r <<< 1;
    x3   = a3_r + bk_r;
    x4   = bk_r - a3_r;
    case (sec2)
      3'd1:    begin n1s = x1;  n2s = x2;  end
      3'd2:    begin n1s = x3;  n2s = x4;  end
      3'd3:    begin n1s = x2;  n2s = -x3; end
      3'd4:    begin n1s = x4;  n2s = -x2; end
      3'd5:    begin n1s = -x3; n2s = x1;  end
      3'd6:    begin n1s = -x2; n2s = x3;  end
      default: begin n1s = '0;  n2s = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec_r <= sec2;
      n1_r  <= (n1s > 0) ? n1s[NW-1:0] : '0;
      n2_r  <= (n2s > 0) ? n2s[NW-1:0] : '0;
    end
  end

  // stage 3: overmodulation test and divisor choice
  logic [VOLT_WIDTH-1:0] bus_eff;
  logic [DW-1:0]         d_norm, n_sum;
  logic [DW-1:0]         n1_3_r, n2_3_r, div_3_r;
  logic [2:0]            sec3_r;
  logic                  over3_r;
  logic                  v3_r;

  assign bus_eff = (bus_r == '0) ? VOLT_WIDTH'(1) : bus_r;
  assign d_norm  = DW'(bus_eff) << 15;
  assign n_sum   = DW'(n1_r) + DW'(n2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      n1_3_r  <= DW'(n1_r);
      n2_3_r  <= DW'(n2_r);
      over3_r <= n_sum > d_norm;
      div_3_r <= (n_sum > d_norm) ? n_sum : d_norm;
      sec3_r  <= sec_r;
    end
  end

  // divider lanes for the two active dwell times
  logic [TW-1:0] t1, t2;

  svpwm_div #(.TIME_WIDTH(TW), .DIV_WIDTH(DW)) u_div_t1 (
    .clk (clk), .en (en), .p (period_r), .n (n1_3_r), .d (div_3_r), .q (t1)
  );

  svpwm_div #(.TIME_WIDTH(TW), .DIV_WIDTH(DW)) u_div_t2 (
    .clk (clk), .en (en), .p (period_r), .n (n2_3_r), .d (div_3_r), .q (t2)
  );

  // sector and overmodulation flag ride alongside the divider
  logic [2:0] sec_pipe_r  [TW];
  logic       over_pipe_r [TW];

  always_ff @(posedge clk) begin
    if (en) begin
      sec_pipe_r[0]  <= sec3_r;
      over_pipe_r[0] <= over3_r;
      for (int k = 1; k < TW; k++) begin
        sec_pipe_r[k]  <= sec_pipe_r[k-1];
        over_pipe_r[k] <= over_pipe_r[k-1];
      end
    end
  end

  // zero-vector time
  logic [TW:0]   t12;
  logic [TW:0]   rest;
  logic [TW-1:0] t1_r, t2_r, t0_r;
  logic [2:0]    sec4_r;

  assign t12  = (TW+1)'(t1) + (TW+1)'(t2);
  assign rest = (TW+1)'(period_r) - t12;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= t1;
      t2_r   <= t2;
      t0_r   <= over_pipe_r[TW-1] ? '0 : rest[TW:1];
      sec4_r <= sec_pipe_r[TW-1];
    end
  end

  // phase compare times, clamped to the period
  logic [TW+1:0] s0, s10, s20, s120, ta, tb, tc;
  logic [TW+1:0] pw;
  logic [TW-1:0] ta_c, tb_c, tc_c;

  always_comb begin
    s0   = (TW+2)'(t0_r);
    s10  = (TW+2)'(t1_r) + s0;
    s20  = (TW+2)'(t2_r) + s0;
    s120 = (TW+2)'(t1_r) + s20;
    pw   = (TW+2)'(period_r);
    case (sec4_r)
      3'd1:    begin ta = s120; tb = s20;  tc = s0;   end
      3'd2:    begin ta = s10;  tb = s120; tc = s0;   end
      3'd3:    begin ta = s0;   tb = s120; tc = s20;  end
      3'd4:    begin ta = s0;   tb = s10;  tc = s120; end
      3'd5:    begin ta = s20;  tb = s0;   tc = s120; end
      3'd6:    begin ta = s120; tb = s0;   tc = s10;  end
      default: begin ta = '0;   tb = '0;   tc = '0;   end
    endcase
    ta_c = (ta > pw) ? period_r : ta[TW-1:0];
    tb_c = (tb > pw) ? period_r : tb[TW-1:0];
    tc_c = (tc > pw) ? period_r : tc[TW-1:0];
  end

  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_W'({tc_c, tb_c, ta_c, sec4_r});
    end
  end

  assign out_tdata = out_data_r;

  // valid bits
  logic [TW-1:0] vdiv_r;
  logic          v4_r;
  logic          vout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      vdiv_r <= '0;
      v4_r   <= 1'b0;
      vout_r <= 1'b0;
    end else if (en) begin
      v1_r   <= in_tvalid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      vdiv_r <= {vdiv_r[TW-2:0], v3_r};
      v4_r   <= vdiv_r[TW-1];
      vout_r <= v4_r;
    end
  end

  assign out_tvalid = vout_r;

endmodule

[hdl/svpwm_checker.sv]
`timescale 1ns / 1ps
// port-level checks for space_vector_pwm_timing_unit, bound to the top level
// depends on the top level's port list and its TIME_WIDTH and OUT_W parameters only
module svpwm_checker #(
  parameter int TIME_WIDTH = 16,
  parameter int OUT_W      = 56
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [2:0]            sec;
  logic [TIME_WIDTH-1:0] ta, tb, tc;

  assign sec = out_tdata[2:0];
  assign ta  = out_tdata[3 +: TIME_WIDTH];
  assign tb  = out_tdata[3+TIME_WIDTH +: TIME_WIDTH];
  assign tc  = out_tdata[3+2*TIME_WIDTH +: TIME_WIDTH];

  // no result comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // sector code stays in range
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sec <= 3'd6)
    else $error("sector out of range");

  // undetermined sector gives all zero compare times
  a_zero_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && sec == 3'd0) |-> (ta == '0 && tb == '0 && tc == '0))
    else $error("zero sector with nonzero times");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind space_vector_pwm_timing_unit svpwm_checker #(
  .TIME_WIDTH(TIME_WIDTH), .OUT_W(OUT_W)
) u_svpwm_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
